// ===== sv/cbls_pkg.sv =====
// Shared types and constants for the cubic Bezier link sampler.
// Holds field widths, register indexes, sequencer codes and reset values.
// Depends on nothing; the top level imports it.
`default_nettype none

package cbls_pkg;

   // Field widths of the stream words and the register port.
   localparam int COORD_W   = 24;
   localparam int BEND_W    = 23;
   localparam int CNT_W     = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 23;

   // Largest segment count the block honors by default.
   localparam int MAX_SEGMENTS_DEF = 63;

   // Control points carry the endpoint plus or minus the bend without saturation.
   localparam int CTRL_W = 26;

   // Curve parameter t and its complement u in Q0.16 with one as 65536.
   localparam int             T_W   = 17;
   localparam logic [T_W-1:0] T_ONE = 17'h10000;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 27;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Square terms u*u and t*t, raw Q0.48 weights and their Q0.24 rounding.
   localparam int SQ_W    = 2 * T_W - 1;
   localparam int PW_W    = 51;
   localparam int W_SHIFT = 24;
   localparam int W_W     = W_SHIFT + 1;

   // Blend accumulator and its value after dropping the weight fraction.
   localparam int ACC_W = 53;
   localparam int RND_W = ACC_W - W_SHIFT;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ORIENTATION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEND        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES     = 2'd2;

   localparam logic              RST_ORIENTATION = 1'b1;
   localparam logic [BEND_W-1:0] RST_BEND        = 23'd12480;
   localparam logic [CNT_W-1:0]  RST_SAMPLES     = 6'd28;

   localparam logic ORIENT_HORIZONTAL = 1'b0;

   // Operations of the shared multiplier, one per sequencer step.
   typedef logic [3:0] op_type;
   localparam op_type OP_UU    = 4'd0;
   localparam op_type OP_TT    = 4'd1;
   localparam op_type OP_W0    = 4'd2;
   localparam op_type OP_W1    = 4'd3;
   localparam op_type OP_W2    = 4'd4;
   localparam op_type OP_W3    = 4'd5;
   localparam op_type OP_X0    = 4'd6;
   localparam op_type OP_X1    = 4'd7;
   localparam op_type OP_X2    = 4'd8;
   localparam op_type OP_X3    = 4'd9;
   localparam op_type OP_Y0    = 4'd10;
   localparam op_type OP_Y1    = 4'd11;
   localparam op_type OP_Y2    = 4'd12;
   localparam op_type OP_Y3    = 4'd13;
   localparam op_type OP_DRAIN = 4'd14;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== sv/cubic_bezier_link_sampler.sv =====
// Cubic Bezier link sampler: turns one link into sampled curve points.
// One shared multiplier runs under a step sequencer; a bit-serial divider sets the t step.
// Depends on cbls_pkg.
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata: start_x, start_y, end_x, end_y
// rsp      out        rsp_tvalid/rsp_tready  tdata: point_x, point_y; tlast: last_point
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// For every link, where N is the effective segment count, the block has one accept step,
// a bit-serial divide for 65536 / N, then 15 steps of the single 34 x 27 multiplier and
// one output step for every point. The input side is ready only when the sequencer is
// idle. A point waits in the output register while the next one is computed; the
// sequencer holds only if that register is still full when the next point is done.
// Reset is synchronous and loads the register reset values; the configuration port is
// always ready.

module cubic_bezier_link_sampler #(
   parameter int unsigned MAX_SEGMENTS = cbls_pkg::MAX_SEGMENTS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Input words.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [4*cbls_pkg::COORD_W-1:0]  req_tdata,  // start_x, start_y, end_x, end_y
   // Result words.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [2*cbls_pkg::COORD_W-1:0]       rsp_tdata,  // point_x, point_y
   output logic                                 rsp_tlast,
   // Register writes.
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [cbls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cbls_pkg::CSR_W-1:0]      csr_data
);

   import cbls_pkg::*;

   // Segment counter width follows the largest segment count.
   localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CNT_W-1:0] MAX_SEG_C = CNT_W'(MAX_SEGMENTS);
   localparam int DIV_CNT_W = $clog2(T_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(T_W - 1);
   localparam logic [PW_W:0]  HALF_W   = (PW_W + 1)'(1) << (W_SHIFT - 1);
   localparam logic [ACC_W-1:0] HALF_A = ACC_W'(1) << (W_SHIFT - 1);

   // Control registers.
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  wb_en_ff, wb_en_in;
   logic                  orient_ff;
   logic [BEND_W-1:0]     bend_ff;
   logic [CNT_W-1:0]      samples_ff;

   // Sequencer and datapath registers.
   op_type                step_ff, step_in;
   op_type                wb_op_ff, wb_op_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [SEG_W-1:0]      n_ff, n_in;
   logic [SEG_W-1:0]      pt_ff, pt_in;
   logic [SEG_W-1:0]      div_rem_ff, div_rem_in;
   logic [T_W-1:0]        q0_ff, q0_in;
   logic [T_W-1:0]        q_ff, q_in;
   logic [SEG_W-1:0]      r_ff, r_in;
   logic signed [CTRL_W-1:0] p0x_ff, p1x_ff, p2x_ff, p3x_ff;
   logic signed [CTRL_W-1:0] p0y_ff, p1y_ff, p2y_ff, p3y_ff;
   logic signed [CTRL_W-1:0] p0x_in, p1x_in, p2x_in, p3x_in;
   logic signed [CTRL_W-1:0] p0y_in, p1y_in, p2y_in, p3y_in;
   logic [SQ_W-1:0]       uu_ff, uu_in, tt_ff, tt_in;
   logic [W_W-1:0]        w0_ff, w1_ff, w2_ff, w3_ff;
   logic [W_W-1:0]        w0_in, w1_in, w2_in, w3_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Combinational helpers.
   logic [T_W-1:0]        t_val, u_val;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic [PW_W-1:0]       pw_raw;
   logic [PW_W:0]         pw_one, pw_three;
   logic [W_W-1:0]        w_one, w_three;
   logic [SEG_W:0]        div_shift;
   logic                  div_ge;
   logic [SEG_W:0]        r_sum;
   logic [CNT_W-1:0]      n_eff;
   logic signed [COORD_W-1:0] sx, sy, ex, ey;
   logic signed [COORD_W-1:0] pt_x, pt_y;
   logic                  can_load;
   logic                  req_fire;

   function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W-1:0]       v;
      logic [RND_W-1:0]       r;
      logic [RND_W-COORD_W:0] upper;
      v     = acc + HALF_A;
      r     = v[ACC_W-1:W_SHIFT];
      upper = r[RND_W-1:COORD_W-1];
      if (upper == '0 || upper == '1) begin
         round_sat = r[COORD_W-1:0];
      end else if (r[RND_W-1]) begin
         round_sat = COORD_MIN;
      end else begin
         round_sat = COORD_MAX;
      end
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign sx = req_tdata[COORD_W-1:0];
   assign sy = req_tdata[2*COORD_W-1:COORD_W];
   assign ex = req_tdata[3*COORD_W-1:2*COORD_W];
   assign ey = req_tdata[4*COORD_W-1:3*COORD_W];

   // A zero count acts as one segment; counts above the limit are clamped.
   assign n_eff = (samples_ff == '0) ? CNT_W'(1) :
                  ((samples_ff > MAX_SEG_C) ? MAX_SEG_C : samples_ff);

   assign t_val = q_ff;
   assign u_val = T_ONE - q_ff;

   // Restoring divide of 65536 by N: the dividend's only set bit enters first.
   assign div_shift = {div_rem_ff, (div_cnt_ff == '0)};
   assign div_ge    = (div_shift >= {1'b0, n_ff});

   // Next t is the rounded quotient, kept as quotient plus remainder.
   assign r_sum = {1'b0, r_ff} + {1'b0, div_rem_ff};

   // Weight rounding from the raw Q0.48 product to Q0.24, plain and times three.
   assign pw_raw   = prod_ff[PW_W-1:0];
   assign pw_one   = {1'b0, pw_raw} + HALF_W;
   assign pw_three = {1'b0, pw_raw} + {pw_raw, 1'b0} + HALF_W;
   assign w_one    = pw_one[W_SHIFT+W_W-1:W_SHIFT];
   assign w_three  = pw_three[W_SHIFT+W_W-1:W_SHIFT];

   assign pt_x = round_sat(acc_x_ff);
   assign pt_y = round_sat(acc_y_ff);

   assign can_load = !rsp_valid_ff || rsp_tready;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         OP_UU: begin mul_a = MUL_A_W'(u_val); mul_b = MUL_B_W'(u_val); end
         OP_TT: begin mul_a = MUL_A_W'(t_val); mul_b = MUL_B_W'(t_val); end
         OP_W0: begin mul_a = MUL_A_W'(uu_ff); mul_b = MUL_B_W'(u_val); end
         OP_W1: begin mul_a = MUL_A_W'(uu_ff); mul_b = MUL_B_W'(t_val); end
         OP_W2: begin mul_a = MUL_A_W'(tt_ff); mul_b = MUL_B_W'(u_val); end
         OP_W3: begin mul_a = MUL_A_W'(tt_ff); mul_b = MUL_B_W'(t_val); end
         OP_X0: begin mul_a = MUL_A_W'(w0_ff); mul_b = MUL_B_W'(p0x_ff); end
         OP_X1: begin mul_a = MUL_A_W'(w1_ff); mul_b = MUL_B_W'(p1x_ff); end
         OP_X2: begin mul_a = MUL_A_W'(w2_ff); mul_b = MUL_B_W'(p2x_ff); end
         OP_X3: begin mul_a = MUL_A_W'(w3_ff); mul_b = MUL_B_W'(p3x_ff); end
         OP_Y0: begin mul_a = MUL_A_W'(w0_ff); mul_b = MUL_B_W'(p0y_ff); end
         OP_Y1: begin mul_a = MUL_A_W'(w1_ff); mul_b = MUL_B_W'(p1y_ff); end
         OP_Y2: begin mul_a = MUL_A_W'(w2_ff); mul_b = MUL_B_W'(p2y_ff); end
         OP_Y3: begin mul_a = MUL_A_W'(w3_ff); mul_b = MUL_B_W'(p3y_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Sequencer and datapath next state.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      wb_en_in     = 1'b0;
      step_in      = step_ff;
      wb_op_in     = step_ff;
      div_cnt_in   = div_cnt_ff;
      n_in         = n_ff;
      pt_in        = pt_ff;
      div_rem_in   = div_rem_ff;
      q0_in        = q0_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      p0x_in = p0x_ff; p1x_in = p1x_ff; p2x_in = p2x_ff; p3x_in = p3x_ff;
      p0y_in = p0y_ff; p1y_in = p1y_ff; p2y_in = p2y_ff; p3y_in = p3y_ff;
      uu_in        = uu_ff;
      tt_in        = tt_ff;
      w0_in = w0_ff; w1_in = w1_ff; w2_in = w2_ff; w3_in = w3_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Write back the product of the previous step.
      if (wb_en_ff) begin
         case (wb_op_ff)
            OP_UU: uu_in = prod_ff[SQ_W-1:0];
            OP_TT: tt_in = prod_ff[SQ_W-1:0];
            OP_W0: w0_in = w_one;
            OP_W1: w1_in = w_three;
            OP_W2: w2_in = w_three;
            OP_W3: w3_in = w_one;
            OP_X0: acc_x_in = $signed(prod_ff[ACC_W-1:0]);
            OP_X1, OP_X2, OP_X3: acc_x_in = acc_x_ff + $signed(prod_ff[ACC_W-1:0]);
            OP_Y0: acc_y_in = $signed(prod_ff[ACC_W-1:0]);
            OP_Y1, OP_Y2, OP_Y3: acc_y_in = acc_y_ff + $signed(prod_ff[ACC_W-1:0]);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // Inner control points: along x for horizontal, along y for vertical.
               p0x_in = CTRL_W'(sx);
               p0y_in = CTRL_W'(sy);
               p3x_in = CTRL_W'(ex);
               p3y_in = CTRL_W'(ey);
               if (orient_ff == ORIENT_HORIZONTAL) begin
                  p1x_in = CTRL_W'(sx) + $signed(CTRL_W'(bend_ff));
                  p1y_in = CTRL_W'(sy);
                  p2x_in = CTRL_W'(ex) - $signed(CTRL_W'(bend_ff));
                  p2y_in = CTRL_W'(ey);
               end else begin
                  p1x_in = CTRL_W'(sx);
                  p1y_in = CTRL_W'(sy) - $signed(CTRL_W'(bend_ff));
                  p2x_in = CTRL_W'(ex);
                  p2y_in = CTRL_W'(ey) + $signed(CTRL_W'(bend_ff));
               end
               n_in       = n_eff[SEG_W-1:0];
               div_cnt_in = '0;
               div_rem_in = '0;
               q0_in      = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            div_rem_in = div_ge ? SEG_W'(div_shift - {1'b0, n_ff}) : div_shift[SEG_W-1:0];
            q0_in      = {q0_ff[T_W-2:0], div_ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               // First point sits at t = 0 with half a segment of rounding credit.
               q_in     = '0;
               r_in     = n_ff >> 1;
               pt_in    = '0;
               step_in  = OP_UU;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_ff == OP_DRAIN) begin
               state_in = ST_EMIT;
            end else begin
               wb_en_in = 1'b1;
               step_in  = step_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pt_x;
               rsp_y_in     = pt_y;
               rsp_last_in  = (pt_ff == n_ff);
               if (pt_ff == n_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  // Step t by 65536 / N, carrying the remainder into the quotient.
                  if (r_sum >= {1'b0, n_ff}) begin
                     r_in = SEG_W'(r_sum - {1'b0, n_ff});
                     q_in = q_ff + q0_ff + 1'b1;
                  end else begin
                     r_in = r_sum[SEG_W-1:0];
                     q_in = q_ff + q0_ff;
                  end
                  pt_in    = pt_ff + 1'b1;
                  step_in  = OP_UU;
                  state_in = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wb_en_ff     <= 1'b0;
         orient_ff    <= RST_ORIENTATION;
         bend_ff      <= RST_BEND;
         samples_ff   <= RST_SAMPLES;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wb_en_ff     <= wb_en_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIENTATION: orient_ff  <= csr_data[0];
               CSR_BEND:        bend_ff    <= csr_data[BEND_W-1:0];
               CSR_SAMPLES:     samples_ff <= csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      wb_op_ff    <= wb_op_in;
      div_cnt_ff  <= div_cnt_in;
      n_ff        <= n_in;
      pt_ff       <= pt_in;
      div_rem_ff  <= div_rem_in;
      q0_ff       <= q0_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      p0x_ff      <= p0x_in;
      p1x_ff      <= p1x_in;
      p2x_ff      <= p2x_in;
      p3x_ff      <= p3x_in;
      p0y_ff      <= p0y_in;
      p1y_ff      <= p1y_in;
      p2y_ff      <= p2y_in;
      p3y_ff      <= p3y_in;
      uu_ff       <= uu_in;
      tt_ff       <= tt_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      w3_ff       <= w3_in;
      prod_ff     <= prod_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for cubic_bezier_link_sampler: streams links in and checks each curve point.
// Expected points come from a fixed-point Bezier evaluator kept in this file.
// Depends on cbls_pkg and the block's top level.

module testbench;
   import cbls_pkg::*;

   // Guard on the run length, sized for the slowest legal run: 64 points per link, each
   // waiting out the longest stall, plus the divide and the sender's gaps.
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int RANDOM_LINKS = 196;
   localparam int MAX_WAIT     = 11;
   localparam int SHOW_LIMIT   = 10;
   // Cycles of quiet after the last point of a batch before the registers are touched.
   localparam int DRAIN_PAUSE  = 24;

   // The index just past the register list; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // One half in the Q0.24 weight scale, used to round the blended sum.
   localparam longint W_HALF = 64'sd8388608;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Input word layout, lowest bits first: start_x, start_y, end_x, end_y.
   typedef struct packed {
      coord_type end_y;
      coord_type end_x;
      coord_type start_y;
      coord_type start_x;
   } link_word_type;

   // Result word layout, lowest bits first: point_x, point_y.
   typedef struct packed {
      coord_type point_y;
      coord_type point_x;
   } point_word_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } curve_point_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [4*COORD_W-1:0]       req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [2*COORD_W-1:0]       rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index  = '0;
   logic [CSR_W-1:0]           csr_data   = '0;

   // Register copies that the point predictor works from.
   logic                       orient_cfg;
   logic [BEND_W-1:0]          bend_cfg;
   logic [CNT_W-1:0]           segs_cfg;

   link_word_type              link_queue[$];
   curve_point_type            expected_points[$];

   int                         links_sent       = 0;
   int                         links_accepted   = 0;
   int                         points_checked   = 0;
   int                         mismatches       = 0;
   int                         settings_applied = 0;
   int                         cycle_count      = 0;

   // Per batch, either side may run with no idling at all.
   bit                         calm_req = 1'b0;
   bit                         calm_rsp = 1'b0;

   int                         req_hold = 0;
   int                         rsp_hold = 0;
   int                         rsp_wait;
   point_word_type             got;
   curve_point_type            want;

   cubic_bezier_link_sampler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // start_x, start_y, end_x, end_y
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // point_x, point_y
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Wait length for one word on either side; a calm batch never idles.
   function automatic int draw_wait(bit calm);
      if (calm)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic void report_mismatch(string what);
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endfunction

   // One axis of the curve: blend the four control coordinates with Q0.24 weights,
   // round the sum half up back to Q15.8 and clamp it to the 24-bit range.
   function automatic coord_type blend_axis(longint w0, longint w1, longint w2, longint w3,
                                            longint c0, longint c1, longint c2, longint c3);
      longint acc;
      acc = w0 * c0 + w1 * c1 + w2 * c2 + w3 * c3;
      acc = (acc + W_HALF) >>> W_SHIFT;
      if (acc > COORD_MAX)
         return COORD_MAX;
      if (acc < COORD_MIN)
         return COORD_MIN;
      return acc[COORD_W-1:0];
   endfunction

   // Queues every point of the curve for one accepted link under the current registers.
   function automatic void predict_curve(link_word_type lk);
      longint            p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y, bend;
      longint unsigned   segs, t, u;
      longint            w0, w1, w2, w3;
      curve_point_type   pt;
      p0x  = longint'(lk.start_x);
      p0y  = longint'(lk.start_y);
      p3x  = longint'(lk.end_x);
      p3y  = longint'(lk.end_y);
      bend = 64'(bend_cfg);
      // A zero segment count behaves as one; the count never exceeds the maximum.
      segs = 64'(segs_cfg);
      if (segs == 0)
         segs = 1;
      if (segs > MAX_SEGMENTS_DEF)
         segs = 64'(MAX_SEGMENTS_DEF);
      if (orient_cfg == ORIENT_HORIZONTAL) begin
         p1x = p0x + bend;
         p1y = p0y;
         p2x = p3x - bend;
         p2y = p3y;
      end else begin
         p1x = p0x;
         p1y = p0y - bend;
         p2x = p3x;
         p2y = p3y + bend;
      end
      for (longint unsigned step = 0; step <= segs; step++) begin
         t  = (step * T_ONE + segs / 2) / segs;
         u  = T_ONE - t;
         w0 = (u * u * u + W_HALF) >> W_SHIFT;
         w1 = (3 * u * u * t + W_HALF) >> W_SHIFT;
         w2 = (3 * u * t * t + W_HALF) >> W_SHIFT;
         w3 = (t * t * t + W_HALF) >> W_SHIFT;
         pt.x    = blend_axis(w0, w1, w2, w3, p0x, p1x, p2x, p3x);
         pt.y    = blend_axis(w0, w1, w2, w3, p0y, p1y, p2y, p3y);
         pt.last = (step == segs);
         expected_points.insert(expected_points.size(), pt);
      end
   endfunction

   // Coordinates lean toward the rails and toward small values around zero.
   function automatic coord_type rand_coord();
      coord_type c;
      c = COORD_W'($urandom);
      case ($urandom_range(0, 7))
         0: c = COORD_MAX;
         1: c = COORD_MIN;
         2, 3: c = {{8{c[15]}}, c[15:0]};
         4: c = '0;
         default: ;
      endcase
      return c;
   endfunction

   // Mostly links as a tree layout makes them, child a modest step from the parent,
   // and the rest with two unrelated endpoints.
   function automatic link_word_type rand_link();
      link_word_type lk;
      logic [31:0]   dx, dy;
      dx = $urandom;
      dy = $urandom;
      lk.start_x = rand_coord();
      lk.start_y = rand_coord();
      if ($urandom_range(0, 2) != 0) begin
         lk.end_x = lk.start_x + {{8{dx[15]}}, dx[15:0]};
         lk.end_y = lk.start_y + {{8{dy[15]}}, dy[15:0]};
      end else begin
         lk.end_x = rand_coord();
         lk.end_y = rand_coord();
      end
      return lk;
   endfunction

   task automatic push_link(input coord_type sx, input coord_type sy, input coord_type ex,
                            input coord_type ey);
      link_word_type lk;
      lk.start_x = sx;
      lk.start_y = sy;
      lk.end_x   = ex;
      lk.end_y   = ey;
      link_queue.insert(link_queue.size(), lk);
      links_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Writes all three registers in a rotated order. Bits above a register's width carry
   // noise, since the block must drop them.
   task automatic apply_setting(input logic o, input logic [BEND_W-1:0] b,
                                input logic [CNT_W-1:0] s, input bit poke_unmapped);
      logic [CSR_W-1:0]     reg_data [4];
      logic [CSR_IDX_W-1:0] idx;
      int                   first;
      reg_data[CSR_ORIENTATION]    = CSR_W'($urandom);
      reg_data[CSR_ORIENTATION][0] = o;
      reg_data[CSR_BEND]           = b;
      reg_data[CSR_SAMPLES]        = CSR_W'($urandom);
      reg_data[CSR_SAMPLES][CNT_W-1:0] = s;
      first = $urandom_range(0, 2);
      if (poke_unmapped)
         write_reg(CSR_UNMAPPED, CSR_W'($urandom));
      for (int k = 0; k < 3; k++) begin
         idx = CSR_IDX_W'((first + k) % 3);
         write_reg(idx, reg_data[idx]);
      end
      calm_req = ($urandom_range(0, 4) == 0);
      calm_rsp = ($urandom_range(0, 4) == 0);
      settings_applied++;
   endtask

   // The block is idle once every queued link went in and every point came out; the
   // short pause after that keeps register writes clear of the output register.
   task automatic wait_drained();
      while (links_accepted != links_sent || expected_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // Predictor side: tracks register writes and turns each accepted link into points.
   // Registers only change while the block is idle, so the order of the two checks
   // within one edge does not matter.
   always @(posedge clock) begin
      if (reset) begin
         orient_cfg = RST_ORIENTATION;
         bend_cfg   = RST_BEND;
         segs_cfg   = RST_SAMPLES;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIENTATION: orient_cfg = csr_data[0];
               CSR_BEND:        bend_cfg   = csr_data[BEND_W-1:0];
               CSR_SAMPLES:     segs_cfg   = csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_curve(link_word_type'(req_tdata));
            links_accepted++;
         end
      end
   end

   // Link driver. A new word goes out only when the slot is free, after the gap that
   // was drawn when the previous word went out.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_hold   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_hold != 0) begin
            req_tvalid <= 1'b0;
            req_hold   <= req_hold - 1;
         end else if (link_queue.size() != 0) begin
            req_tdata  <= link_queue.pop_front();
            req_tvalid <= 1'b1;
            req_hold   <= draw_wait(calm_req);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Point monitor. Every word taken is compared with the oldest expected point; after
   // each word the ready line drops for a freshly drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_points.size() == 0) begin
            report_mismatch($sformatf("unexpected word x=%0d y=%0d last=%0b",
                                      got.point_x, got.point_y, rsp_tlast));
         end else begin
            want = expected_points.pop_front();
            points_checked++;
            if (got.point_x !== want.x || got.point_y !== want.y || rsp_tlast !== want.last)
               report_mismatch($sformatf(
                  "point %0d: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                  points_checked, want.x, want.y, want.last,
                  got.point_x, got.point_y, rsp_tlast));
         end
         rsp_wait = draw_wait(calm_rsp);
         if (rsp_wait != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= rsp_wait - 1;
         end
      end else if (!rsp_tready) begin
         if (rsp_hold == 0)
            rsp_tready <= 1'b1;
         else
            rsp_hold <= rsp_hold - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout: %0d links sent, %0d accepted, %0d points still expected",
                  links_sent, links_accepted, expected_points.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      link_word_type     lk;
      logic [BEND_W-1:0] bend;
      logic [CNT_W-1:0]  segs;
      int                pick;
      int                batch;
      int                random_links;
      random_links = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Register values from reset: vertical bend of 12480 over 28 segments. The rail
      // corners push both inner control points past the 24-bit range.
      push_link(0, 0, 0, 0);
      push_link(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      push_link(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      push_link(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
      wait_drained();

      // Horizontal with the largest bend and a zero segment count, which must give two
      // points per link; a write past the register list goes in first.
      apply_setting(ORIENT_HORIZONTAL, '1, 0, 1'b1);
      push_link(COORD_MAX, 0, COORD_MAX, 0);
      push_link(COORD_MIN, 5, COORD_MIN, -5);
      push_link(0, 0, 0, 0);
      push_link(1, -1, -1, 1);
      wait_drained();

      // Vertical with the largest bend and the most segments. The second link bows
      // beyond both rails and saturates.
      apply_setting(~ORIENT_HORIZONTAL, '1, CNT_W'(MAX_SEGMENTS_DEF), 1'b0);
      push_link(0, COORD_MAX, 0, COORD_MIN);
      push_link(0, COORD_MIN, 0, COORD_MAX);
      wait_drained();

      // No bend at all and a single segment: only the two endpoints come out.
      apply_setting(ORIENT_HORIZONTAL, '0, 1, 1'b0);
      push_link(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      push_link(24'sh123456, -24'sh654321, -24'sh0ABCDE, 24'sh0F0F0F);
      wait_drained();

      // Two typical small tree links with three segments.
      apply_setting(ORIENT_HORIZONTAL, 23'd10240, 3, 1'b0);
      push_link(24'sd2560, 24'sd5120, 24'sd12800, -24'sd2560);
      push_link(-24'sd256, 24'sd0, 24'sd256, 24'sd65536);
      wait_drained();

      // Random batches, each under freshly drawn registers. Most batches use few
      // segments; the largest count is rare and then carries only a few links.
      while (random_links < RANDOM_LINKS) begin
         case ($urandom_range(0, 3))
            0: bend = '0;
            1: bend = '1;
            2: bend = BEND_W'($urandom_range(0, 16'hFFFF));
            default: bend = BEND_W'($urandom);
         endcase
         pick = $urandom_range(0, 11);
         if (pick == 0)
            segs = 0;
         else if (pick == 1)
            segs = CNT_W'(MAX_SEGMENTS_DEF);
         else if (pick <= 3)
            segs = CNT_W'($urandom_range(9, 28));
         else
            segs = CNT_W'($urandom_range(1, 8));
         apply_setting(1'($urandom_range(0, 1)), bend, segs, $urandom_range(0, 3) == 0);
         batch = (segs > 28) ? $urandom_range(1, 3) : $urandom_range(6, 18);
         repeat (batch) begin
            lk = rand_link();
            push_link(lk.start_x, lk.start_y, lk.end_x, lk.end_y);
            random_links++;
         end
         wait_drained();
      end

      $display("Sent %0d links under %0d register settings, both layouts, bends from 0 to max.",
               links_sent, settings_applied);
      $display("Compared %0d curve points; %0d mismatches found.", points_checked, mismatches);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
